>>> sv/jsc_pkg.sv
package jsc_pkg;

  localparam int ADDR_BITS  = 16;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [15:0] ADDR_MASK = 16'((64'd1 << ADDR_BITS) - 64'd1);

  localparam logic [7:0] BYTE_FF  = 8'hFF;
  localparam logic [7:0] BYTE_SOI = 8'hD8;
  localparam logic [7:0] BYTE_EOI = 8'hD9;

  localparam logic CFG_BUFFER_SIZE    = 1'b0;
  localparam logic CFG_BUFFER_PRESENT = 1'b1;

  typedef enum logic [2:0] {
    EV_NONE        = 3'd0,
    EV_COMPLETE    = 3'd1,
    EV_DROP_NOBUF  = 3'd2,
    EV_DROP_OVER   = 3'd3,
    EV_END_IDLE    = 3'd4,
    EV_OVERFLOW    = 3'd5
  } event_t;

  typedef enum logic [1:0] {
    RX_IDLE    = 2'd0,
    RX_STARTED = 2'd1,
    RX_OVER    = 2'd2
  } rx_state_t;

  // at most one queue entry per byte; pre marks the extra FF write to address 0
  typedef struct packed {
    logic        pre;
    logic        we;
    logic [15:0] addr;
    logic [7:0]  data;
    event_t      ev;
    logic [16:0] len;
  } cmd_t;

endpackage

>>> sv/jsc_front.sv
module jsc_front import jsc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        accept,
  input  logic [7:0]  data_byte,
  output logic        push,
  output cmd_t        cmd
);

  rx_state_t   st_r, st_nxt;
  logic [7:0]  prev_r, prev_nxt;
  logic [15:0] idx_r, idx_nxt;
  logic        br_r, br_nxt;
  logic [15:0] size_r;
  logic        present_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r    <= 16'hFFFF;
      present_r <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index == CFG_BUFFER_SIZE) begin
        size_r <= cfg_wdata;
      end else begin
        present_r <= cfg_wdata[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= RX_IDLE;
      prev_r <= '0;
      idx_r  <= '0;
      br_r   <= 1'b0;
    end else if (accept) begin
      st_r   <= st_nxt;
      prev_r <= prev_nxt;
      idx_r  <= idx_nxt;
      br_r   <= br_nxt;
    end
  end

  always_comb begin
    logic   eoi, soi, open_wr, pend;
    logic [7:0] pdata;
    logic [15:0] paddr;
    event_t pev;
    eoi     = (data_byte == BYTE_EOI) && (prev_r == BYTE_FF);
    soi     = (data_byte == BYTE_SOI) && (prev_r == BYTE_FF);
    open_wr = (st_r == RX_STARTED) && br_r;
    st_nxt   = st_r;
    prev_nxt = data_byte;
    idx_nxt  = idx_r;
    br_nxt   = br_r;
    pend     = 1'b0;
    paddr    = '0;
    pdata    = '0;
    pev      = EV_NONE;
    cmd      = '0;
    push     = 1'b0;
    if (eoi) begin
      unique case (st_r)
        RX_STARTED: begin
          pev    = br_r ? EV_COMPLETE : EV_DROP_NOBUF;
          st_nxt = RX_IDLE;
        end
        RX_OVER: pev = EV_DROP_OVER;
        default: pev = EV_END_IDLE;
      endcase
      cmd.we   = open_wr;
      cmd.addr = open_wr ? (idx_r & ADDR_MASK) : 16'd0;
      cmd.data = open_wr ? data_byte : 8'd0;
      cmd.ev   = pev;
      cmd.len  = (pev == EV_COMPLETE) ? ({1'b0, idx_r} + 17'd1) : 17'd0;
      push     = 1'b1;
      idx_nxt  = '0;
      prev_nxt = '0;
    end else begin
      if (soi) begin
        if (st_r == RX_IDLE || (st_r == RX_OVER && !br_r)) begin
          br_nxt = present_r;
        end
        st_nxt = RX_STARTED;
        if (br_nxt) begin
          cmd.pre = 1'b1;
          pend    = 1'b1;
          paddr   = 16'd1;
          pdata   = BYTE_SOI;
          idx_nxt = 16'd1;
        end
      end else if (open_wr) begin
        pend  = 1'b1;
        paddr = idx_r;
        pdata = data_byte;
      end
      // overflow check runs on the index left by this byte
      if (st_nxt == RX_STARTED) begin
        if (idx_nxt < size_r) begin
          idx_nxt = idx_nxt + 16'd1;
        end else begin
          st_nxt = RX_OVER;
          pev    = EV_OVERFLOW;
        end
      end
      cmd.we   = pend;
      cmd.addr = paddr & ADDR_MASK;
      cmd.data = pdata;
      cmd.ev   = pev;
      cmd.len  = '0;
      push     = pend || (pev != EV_NONE);
    end
    push = push && accept;
  end

endmodule

>>> sv/jsc_fifo.sv
module jsc_fifo import jsc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic not_empty,
  output cmd_t head
);

  cmd_t                mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_r, rd_r;
  logic [FIFO_AW:0]    cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      cnt_r <= cnt_r + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end
  end

  assign full      = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_r];

endmodule

>>> sv/jsc_back.sv
module jsc_back import jsc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        not_empty,
  input  cmd_t        head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_write_enable,
  output logic [15:0] out_write_address,
  output logic [7:0]  out_write_data,
  output logic [2:0]  out_event_code,
  output logic [16:0] out_frame_length,
  output logic        out_last_result
);

  logic        valid_r;
  logic        pre_done_r;
  logic        load;
  logic        emit_pre;
  logic        we_r, last_r;
  logic [15:0] addr_r;
  logic [7:0]  data_r;
  event_t      ev_r;
  logic [16:0] len_r;

  assign load     = not_empty && (!valid_r || out_ready);
  assign emit_pre = head.pre && !pre_done_r;
  assign pop      = load && !emit_pre;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      pre_done_r <= 1'b0;
    end else begin
      if (load) begin
        valid_r    <= 1'b1;
        pre_done_r <= emit_pre;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  // start marker: FF to address 0 goes out ahead of the queued write
  always_ff @(posedge clk) begin
    if (load) begin
      if (emit_pre) begin
        we_r   <= 1'b1;
        addr_r <= '0;
        data_r <= BYTE_FF;
        ev_r   <= EV_NONE;
        len_r  <= '0;
        last_r <= 1'b0;
      end else begin
        we_r   <= head.we;
        addr_r <= head.addr;
        data_r <= head.data;
        ev_r   <= head.ev;
        len_r  <= head.len;
        last_r <= 1'b1;
      end
    end
  end

  assign out_valid         = valid_r;
  assign out_write_enable  = we_r;
  assign out_write_address = addr_r;
  assign out_write_data    = data_r;
  assign out_event_code    = ev_r;
  assign out_frame_length  = len_r;
  assign out_last_result   = last_r;

endmodule

>>> sv/jpeg_soi_eoi_frame_capture.sv
// path: a byte's results are written into the command queue and then registered
// in the output stage before they are presented
// throughput: one byte per cycle; a start marker needs an extra output result, the
// 4-entry command queue soaks these up and input stalls only when it is full
// reset: synchronous active low; receive state idle, index and previous byte
// cleared, buffer_size 65535, buffer_present 1, queue and output emptied
module jpeg_soi_eoi_frame_capture import jsc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_write_enable,
  output logic [15:0] out_write_address,
  output logic [7:0]  out_write_data,
  output logic [2:0]  out_event_code,
  output logic [16:0] out_frame_length,
  output logic        out_last_result
);

  logic accept, push, pop, full, not_empty;
  cmd_t cmd, head;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  jsc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .data_byte (in_data_byte),
    .push      (push),
    .cmd       (cmd)
  );

  jsc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (cmd),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head      (head)
  );

  jsc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .not_empty         (not_empty),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_write_enable  (out_write_enable),
    .out_write_address (out_write_address),
    .out_write_data    (out_write_data),
    .out_event_code    (out_event_code),
    .out_frame_length  (out_frame_length),
    .out_last_result   (out_last_result)
  );

endmodule
